[hdl/xss_pkg.sv]
`timescale 1ns / 1ps

package xss_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned HALF_W  = WORD_W / 2;

  localparam int unsigned STATE_WORDS_DEF = 16;

  // Generator constants
  localparam logic [WORD_W-1:0] MULTIPLIER   = 64'h9e37_79b9_7f4a_7c13;
  localparam logic [LIM_W-1:0]  BERN_MODULUS = 31'h7fff_ffff;
  localparam int unsigned       SHL_A        = 31;
  localparam int unsigned       SHR_A        = 11;
  localparam int unsigned       SHR_B        = 30;

  // Sequencing of the shared multiplier and the bit-serial reducer
  localparam int unsigned       CNT_W    = $clog2(WORD_W);
  localparam logic [CNT_W-1:0]  MUL_LAST = CNT_W'(2);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(WORD_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_SEED      = 2'd0,
    OP_RAW       = 2'd1,
    OP_BOUNDED   = 2'd2,
    OP_BERNOULLI = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_NEW,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

[hdl/xss_req_if.sv]
`timescale 1ns / 1ps

interface xss_req_if;
  logic                          valid;
  logic                          ready;
  logic [xss_pkg::OP_W-1:0]      operation;
  logic [xss_pkg::SLOT_W-1:0]    seed_slot;
  logic [xss_pkg::WORD_W-1:0]    seed_word;
  logic [xss_pkg::LIM_W-1:0]     bound;
  logic [xss_pkg::LIM_W-1:0]     threshold;

  modport source (
    output valid, operation, seed_slot, seed_word, bound, threshold,
    input  ready
  );

  modport sink (
    input  valid, operation, seed_slot, seed_word, bound, threshold,
    output ready
  );
endinterface

[hdl/xss_rsp_if.sv]
`timescale 1ns / 1ps

interface xss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [xss_pkg::WORD_W-1:0]    value;
  logic                          success;

  modport source (
    output valid, value, success,
    input  ready
  );

  modport sink (
    input  valid, value, success,
    output ready
  );
endinterface

[hdl/xorshift_star_random_source.sv]
`timescale 1ns / 1ps
// xorshift1024* random source.
// Requests arrive on req_i (valid/ready); each request transaction is a seed
// write or a draw. A seed write loads one of the sixteen 64-bit state words,
// leaves the position alone and gives no response. A draw advances the
// generator once and gives one response transaction on rsp_o: the raw
// product, the product modulo bound, or the product modulo 2^31-1 together
// with a success flag (reduced value below threshold).
// A raw draw runs from acceptance until the result is loaded into the output
// register through two reads of the state memory, one write back and three
// passes of a shared 32x32 multiplier. Bounded and bernoulli draws add the
// bit-serial remainder before the load. One request is worked on at a time;
// ready is high only between draws.
// Reset clears the position, the output valid flag and the per-word valid
// bits, so every state word reads as zero until seeded; no clearing pass.
// A stalled receiver holds the response in the output register; the block
// still takes the next request and works on it, and waits only when a second
// result is ready before the first has been taken.

module xorshift_star_random_source #(
  parameter int unsigned STATE_WORDS = xss_pkg::STATE_WORDS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  xss_req_if.sink   req_i,
  xss_rsp_if.source rsp_o
);

  import xss_pkg::*;

  localparam int unsigned AW = $clog2(STATE_WORDS);

  // Control state
  state_e              state_q, state_d;
  logic [AW-1:0]       pos_q;
  logic [AW-1:0]       pos_nxt;
  logic [CNT_W-1:0]    cnt_q;
  logic [STATE_WORDS-1:0] valid_q;
  logic                vld_rd_q;
  logic                out_vld_q;

  // Payload registers
  op_e                 op_q;
  logic [LIM_W-1:0]    div_q;
  logic [LIM_W-1:0]    thr_q;
  logic [WORD_W-1:0]   old_q;
  logic [WORD_W-1:0]   mixed_q;
  logic [WORD_W-1:0]   acc_q;
  logic [LIM_W-1:0]    rem_q;
  logic [WORD_W-1:0]   value_q;
  logic                success_q;

  // Memory port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                req_ready;
  logic                req_fire;
  op_e                 req_op;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   mix_t;
  logic [WORD_W-1:0]   mixed;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [WORD_W-1:0]   mul_p;
  logic [LIM_W:0]      rem_sh;
  logic                rem_ge;
  logic                out_load;
  logic [WORD_W-1:0]   res_value;
  logic                res_success;

  assign req_op   = op_e'(req_i.operation);
  assign req_fire = req_i.valid && req_ready;
  assign pos_nxt  = pos_q + 1'b1;

  // Words never seeded read as zero
  assign rd_word = vld_rd_q ? ram_rdata : '0;

  // Mix the word at the new position with the word at the old one
  assign mix_t = rd_word ^ (rd_word << SHL_A);
  assign mixed = mix_t ^ old_q ^ (mix_t >> SHR_A) ^ (old_q >> SHR_B);

  xss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid && req_op != OP_SEED) begin
          state_d = ST_RD_OLD;
        end
      end
      ST_RD_OLD: state_d = ST_RD_NEW;
      ST_RD_NEW: state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = (op_q == OP_RAW) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (memory port and request ready)
  // ---------------------------------------------------------------------
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = req_i.seed_slot[AW-1:0];
    ram_wdata = req_i.seed_word;
    ram_re    = 1'b0;
    ram_raddr = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          if (req_op == OP_SEED) begin
            ram_we = 1'b1;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_RD_OLD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_nxt;
      end
      ST_RD_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_nxt;
        ram_wdata = mixed;
      end
      default: ;
    endcase
  end

  assign req_i.ready = req_ready;

  // ---------------------------------------------------------------------
  // Shared 32x32 multiplier: low 64 bits of mixed * MULTIPLIER in three
  // passes (lo*lo, lo*hi, hi*lo), accumulated into acc_q
  // ---------------------------------------------------------------------
  always_comb begin
    case (cnt_q)
      CNT_W'(0): begin
        mul_a = mixed_q[HALF_W-1:0];
        mul_b = MULTIPLIER[HALF_W-1:0];
      end
      CNT_W'(1): begin
        mul_a = mixed_q[HALF_W-1:0];
        mul_b = MULTIPLIER[WORD_W-1:HALF_W];
      end
      default: begin
        mul_a = mixed_q[WORD_W-1:HALF_W];
        mul_b = MULTIPLIER[HALF_W-1:0];
      end
    endcase
  end

  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  // One restoring step of the remainder; the dividend leaves acc_q MSB first
  assign rem_sh = {rem_q, acc_q[WORD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_q};

  // Result selection; a bound of zero gives zero
  always_comb begin
    res_success = 1'b0;
    if (op_q == OP_RAW) begin
      res_value = acc_q;
    end else if (div_q == '0) begin
      res_value = '0;
    end else begin
      res_value   = WORD_W'(rem_q);
      res_success = (op_q == OP_BERNOULLI) && (rem_q < thr_q);
    end
  end

  // Load the output register when it is empty or being drained
  assign out_load = (state_q == ST_FIN) && (!out_vld_q || rsp_o.ready);

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
      vld_rd_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= valid_q[ram_raddr];
      end
      // Advance the position once the mixed word is written back
      if (state_q == ST_RD_NEW) begin
        pos_q <= pos_nxt;
      end
      if ((state_q == ST_MUL && cnt_q != MUL_LAST) || state_q == ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_op;
      div_q <= (req_op == OP_BERNOULLI) ? BERN_MODULUS : req_i.bound;
      thr_q <= req_i.threshold;
    end
    if (state_q == ST_RD_OLD) begin
      old_q <= rd_word;
    end
    if (state_q == ST_RD_NEW) begin
      mixed_q <= mixed;
    end
    if (state_q == ST_MUL) begin
      rem_q <= '0;
      if (cnt_q == '0) begin
        acc_q <= mul_p;
      end else begin
        acc_q <= acc_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end else if (state_q == ST_DIV) begin
      acc_q <= {acc_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_ge ? LIM_W'(rem_sh - {1'b0, div_q}) : rem_sh[LIM_W-1:0];
    end
    if (out_load) begin
      value_q   <= res_value;
      success_q <= res_success;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.value   = value_q;
  assign rsp_o.success = success_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("response raised without a finished draw");

  a_pos_on_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != $past(pos_q)) |-> $past(state_q == ST_RD_NEW))
    else $error("position moved outside a draw");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_q != '0) |-> (rem_q < div_q))
    else $error("partial remainder not reduced");

  a_success_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && success_q) |-> (value_q[WORD_W-1:LIM_W] == '0))
    else $error("success flagged on an unreduced value");

endmodule

[hdl/xss_ram.sv]
`timescale 1ns / 1ps

module xss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
